// ===== rtl/core/mesh_child_route_forwarder_core_assert.svh =====
// Assertion macros used by the route forwarder checker
`ifndef MESH_CHILD_ROUTE_FORWARDER_CORE_ASSERT_SVH
`define MESH_CHILD_ROUTE_FORWARDER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define MCRF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("route forwarder check failed");

// Next-cycle implication, disabled while reset is asserted
`define MCRF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("route forwarder check failed");

`endif

// ===== rtl/core/mcrf_pkg.sv =====
// Types, constants and codes for the mesh child route forwarder
package mcrf_pkg;

	// Table geometry
	localparam int TABLE_ENTRIES = 256;
	localparam int TBL_AW        = $clog2(TABLE_ENTRIES);

	localparam logic [7:0] GATEWAY_ID = 8'd0;
	localparam logic [7:0] NO_ROUTE   = 8'hFF;
	localparam logic [7:0] CMD_REPORT = 8'd70;
	localparam logic [7:0] CMD_CLEAR  = 8'd67;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_NODE_ID      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PARENT_ID    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HOP_DISTANCE = 2'd2;

	// Operation, class and internal kind codes
	localparam logic       OP_RECEIVE   = 1'b0;
	localparam logic       OP_SEND      = 1'b1;
	localparam logic [1:0] CLS_INTERNAL = 2'd0;
	localparam logic [1:0] CLS_SET_VAR  = 2'd1;
	localparam logic [1:0] KIND_PING    = 2'd0;
	localparam logic [1:0] KIND_RELAY   = 2'd1;
	localparam logic [1:0] KIND_CHILDREN = 2'd2;

	// Action codes
	localparam logic [3:0] ACT_DELIVER     = 4'd0;
	localparam logic [3:0] ACT_TO_CHILD    = 4'd1;
	localparam logic [3:0] ACT_TO_PARENT   = 4'd2;
	localparam logic [3:0] ACT_PING_ACK    = 4'd3;
	localparam logic [3:0] ACT_REFRESH     = 4'd4;
	localparam logic [3:0] ACT_REPORT      = 4'd5;
	localparam logic [3:0] ACT_CLEARED     = 4'd6;
	localparam logic [3:0] ACT_DROP_CMD    = 4'd7;
	localparam logic [3:0] ACT_GW_NO_ROUTE = 4'd8;
	localparam logic [3:0] ACT_SENDER_RM   = 4'd9;
	localparam logic [3:0] ACT_SEND_UP     = 4'd10;
	localparam logic [3:0] ACT_OUT_DROP    = 4'd11;

	typedef struct packed {
		logic       operation;
		logic [7:0] from_node;
		logic [7:0] to_node;
		logic [7:0] last_hop;
		logic       on_own_pipe;
		logic [1:0] msg_class;
		logic [1:0] internal_kind;
		logic [7:0] command_char;
	} mcrf_item_t;

	typedef struct packed {
		logic [3:0] action;
		logic [7:0] next_hop;
		logic [7:0] reply_value;
		logic       ack_to_gateway;
		logic       store_write;
		logic [7:0] store_index;
		logic [7:0] store_value;
		logic       store_clear_all;
	} mcrf_result_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE    = 3'b001,
		ST_RD_FROM = 3'b010,
		ST_DECIDE  = 3'b100
	} mcrf_state_t;

endpackage

// ===== rtl/core/mesh_child_route_forwarder_core.sv =====
// Top level of the mesh child route forwarder: route table and decision sequencer
//
//   channel   dir  handshake            payload
//   item      in   start & !busy        mcrf_item_t
//   result    out  done (one cycle)     mcrf_result_t
//   config    in   cfg_we               cfg_index, cfg_data
//
// For each item the single table port reads the destination entry, then the
// sender entry, then writes the sender entry back if it changed. The result
// strobe is registered from the decide state; a new item is taken while it shows.
// Reset and the clear command empty the table at once through per-entry valid
// bits; no sweep runs. The receiver cannot stall results.
module mesh_child_route_forwarder_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  mcrf_pkg::mcrf_item_t             item,
	output logic                             done,
	output mcrf_pkg::mcrf_result_t           result,
	input  logic                             cfg_we,
	input  logic [mcrf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [7:0]                       cfg_data
);

	localparam int AW = mcrf_pkg::TBL_AW;

	mcrf_pkg::mcrf_state_t  state_q;
	mcrf_pkg::mcrf_item_t   item_q;
	mcrf_pkg::mcrf_result_t result_q;
	mcrf_pkg::mcrf_result_t res_d;
	logic [7:0]  node_id_q;
	logic [7:0]  parent_id_q;
	logic [7:0]  hop_distance_q;
	logic [mcrf_pkg::TABLE_ENTRIES-1:0] vld_q;
	logic        rvld_q;
	logic        done_q;
	logic [7:0]  route_q;
	logic [7:0]  addr_id;
	logic [AW-1:0] addr_idx;
	logic        addr_in_range;
	logic        from_in_range;
	logic [7:0]  ram_rdata;
	logic [7:0]  rd_val;
	logic        ram_we;
	logic        tbl_we;
	logic        clr_all;
	logic        wr_req;
	logic [7:0]  wr_val;
	logic        accept;

	assign accept = start && (state_q == mcrf_pkg::ST_IDLE);
	assign busy   = (state_q != mcrf_pkg::ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

	// Table port address: destination while idle, sender afterwards
	assign addr_id       = (state_q == mcrf_pkg::ST_IDLE) ? item.to_node : item_q.from_node;
	assign addr_idx      = addr_id[AW-1:0];
	assign addr_in_range = ({1'b0, addr_id} < 9'(mcrf_pkg::TABLE_ENTRIES));
	assign from_in_range = ({1'b0, item_q.from_node} < 9'(mcrf_pkg::TABLE_ENTRIES));
	assign rd_val        = rvld_q ? ram_rdata : mcrf_pkg::NO_ROUTE;
	assign ram_we        = (state_q == mcrf_pkg::ST_DECIDE) && tbl_we;

	mcrf_ram #(
		.WIDTH(8),
		.DEPTH(mcrf_pkg::TABLE_ENTRIES)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.addr (addr_idx),
		.wdata(wr_val),
		.rdata(ram_rdata)
	);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_id_q      <= '0;
			parent_id_q    <= '0;
			hop_distance_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				mcrf_pkg::REG_NODE_ID:      node_id_q      <= cfg_data;
				mcrf_pkg::REG_PARENT_ID:    parent_id_q    <= cfg_data;
				mcrf_pkg::REG_HOP_DISTANCE: hop_distance_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Decide the outcome from the destination route and the old sender entry
	always_comb begin
		res_d   = '0;
		wr_req  = 1'b0;
		wr_val  = mcrf_pkg::NO_ROUTE;
		clr_all = 1'b0;
		tbl_we  = 1'b0;
		if (item_q.operation == mcrf_pkg::OP_SEND) begin
			if (route_q != 8'd0 && route_q != mcrf_pkg::NO_ROUTE &&
				item_q.to_node != mcrf_pkg::GATEWAY_ID) begin
				res_d.action   = mcrf_pkg::ACT_TO_CHILD;
				res_d.next_hop = route_q;
			end else if (node_id_q != mcrf_pkg::GATEWAY_ID) begin
				res_d.action   = mcrf_pkg::ACT_SEND_UP;
				res_d.next_hop = parent_id_q;
			end else begin
				res_d.action = mcrf_pkg::ACT_OUT_DROP;
			end
		end else if (item_q.msg_class == mcrf_pkg::CLS_INTERNAL &&
			item_q.internal_kind == mcrf_pkg::KIND_PING) begin
			res_d.action      = mcrf_pkg::ACT_PING_ACK;
			res_d.next_hop    = item_q.from_node;
			res_d.reply_value = hop_distance_q;
		end else if (item_q.to_node == node_id_q) begin
			if (item_q.msg_class == mcrf_pkg::CLS_INTERNAL &&
				item_q.internal_kind == mcrf_pkg::KIND_RELAY &&
				item_q.to_node != mcrf_pkg::GATEWAY_ID) begin
				res_d.action      = mcrf_pkg::ACT_REFRESH;
				res_d.next_hop    = parent_id_q;
				res_d.reply_value = parent_id_q;
			end else if (item_q.msg_class == mcrf_pkg::CLS_INTERNAL &&
				item_q.internal_kind == mcrf_pkg::KIND_CHILDREN &&
				item_q.to_node != mcrf_pkg::GATEWAY_ID) begin
				if (item_q.command_char == mcrf_pkg::CMD_REPORT) begin
					res_d.action   = mcrf_pkg::ACT_REPORT;
					res_d.next_hop = parent_id_q;
				end else if (item_q.command_char == mcrf_pkg::CMD_CLEAR) begin
					res_d.action          = mcrf_pkg::ACT_CLEARED;
					res_d.next_hop        = parent_id_q;
					res_d.store_clear_all = 1'b1;
					clr_all               = 1'b1;
				end else begin
					res_d.action = mcrf_pkg::ACT_DROP_CMD;
				end
			end else begin
				res_d.action         = mcrf_pkg::ACT_DELIVER;
				res_d.ack_to_gateway = (item_q.msg_class == mcrf_pkg::CLS_SET_VAR) &&
					(item_q.from_node == mcrf_pkg::GATEWAY_ID);
				wr_req = (item_q.last_hop != mcrf_pkg::GATEWAY_ID);
				wr_val = item_q.last_hop;
			end
		end else if (route_q != 8'd0 && route_q != mcrf_pkg::NO_ROUTE) begin
			res_d.action   = mcrf_pkg::ACT_TO_CHILD;
			res_d.next_hop = route_q;
		end else if (item_q.on_own_pipe) begin
			res_d.action   = mcrf_pkg::ACT_TO_PARENT;
			res_d.next_hop = parent_id_q;
			wr_req         = 1'b1;
			wr_val         = item_q.last_hop;
		end else if (node_id_q == mcrf_pkg::GATEWAY_ID) begin
			res_d.action = mcrf_pkg::ACT_GW_NO_ROUTE;
		end else begin
			res_d.action = mcrf_pkg::ACT_SENDER_RM;
			wr_req       = 1'b1;
			wr_val       = mcrf_pkg::NO_ROUTE;
		end
		// Write back only a real change of an entry inside the table
		if (wr_req && from_in_range && (rd_val != wr_val)) begin
			tbl_we            = 1'b1;
			res_d.store_write = 1'b1;
			res_d.store_index = item_q.from_node;
			res_d.store_value = wr_val;
		end
	end

	// Sequencer, valid bits and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mcrf_pkg::ST_IDLE;
			vld_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == mcrf_pkg::ST_DECIDE);
			case (state_q)
				mcrf_pkg::ST_IDLE: begin
					if (accept) begin
						state_q <= mcrf_pkg::ST_RD_FROM;
					end
				end
				mcrf_pkg::ST_RD_FROM: begin
					state_q <= mcrf_pkg::ST_DECIDE;
				end
				mcrf_pkg::ST_DECIDE: begin
					state_q <= mcrf_pkg::ST_IDLE;
					if (clr_all) begin
						vld_q <= '0;
					end else if (tbl_we) begin
						vld_q[item_q.from_node[AW-1:0]] <= 1'b1;
					end
				end
				default: state_q <= mcrf_pkg::ST_IDLE;
			endcase
		end
	end

	// Hold the item, the destination route, the read valid flag and the result
	always_ff @(posedge clk) begin
		rvld_q <= addr_in_range && vld_q[addr_idx];
		if (accept) begin
			item_q <= item;
		end
		if (state_q == mcrf_pkg::ST_RD_FROM) begin
			route_q <= rd_val;
		end
		if (state_q == mcrf_pkg::ST_DECIDE) begin
			result_q <= res_d;
		end
	end

endmodule

// ===== rtl/core/mcrf_ram.sv =====
// Generic single-port RAM with registered read data
module mcrf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Read-first: a read during a write returns the old contents
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

// ===== rtl/core/mcrf_checker.sv =====
// Port-level checker for the mesh child route forwarder, bound to the top level
`include "mesh_child_route_forwarder_core_assert.svh"

module mcrf_checker (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   start,
	input logic                   busy,
	input logic                   done,
	input mcrf_pkg::mcrf_result_t result
);

	// An accepted word makes the block busy
	`MCRF_ASSERT_NXT(a_accept_busy, clk, arst_n, start && !busy, busy)

	// Every accepted word yields its result strobe
	`MCRF_ASSERT_IMP(a_accept_done, clk, arst_n, start && !busy, ##3 done)

	// A result closes the work: busy before, idle while shown
	`MCRF_ASSERT_IMP(a_done_idle, clk, arst_n, done, !busy && $past(busy))

	// A single-entry update never comes with a full clear
	`MCRF_ASSERT_IMP(a_store_excl, clk, arst_n, done,
		!(result.store_write && result.store_clear_all))

endmodule

bind mesh_child_route_forwarder_core mcrf_checker u_mcrf_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.done  (done),
	.result(result)
);
